### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(cond)) \
        else $error(msg);

`else

`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop, msg)
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond, msg)

`endif

`endif

### hw/rtl/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared types, register indexes and alphabet helpers for the Gronsfeld
// stream cipher.
// ----------------------------------------------------------------------------
package gsc_pkg;

    // Widths fixed by the item and register formats
    localparam int CODE_W    = 16;
    localparam int KEY_W     = 64;
    localparam int LEN_W     = 5;
    localparam int DIGIT_W   = 4;
    localparam int POS_W     = 4;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam int DEFAULT_MAX_KEY_DIGITS = 16;

    // Alphabet: 33 Cyrillic capitals then 24 Latin capitals (no J, no M)
    localparam int ALPHA_SIZE = 57;
    localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_DIGITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd2;

    // Per-character control handed from the key sequencer to the datapath
    typedef struct packed {
        logic               decrypt;
        logic [DIGIT_W-1:0] shift;
    } key_ctl_t;

    // Result of an alphabet lookup
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } alpha_hit_t;

    localparam logic [CODE_W-1:0] ALPHA_CODES [ALPHA_SIZE] = '{
        16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0401,
        16'h0416, 16'h0417, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C,
        16'h041D, 16'h041E, 16'h041F, 16'h0420, 16'h0421, 16'h0422, 16'h0423,
        16'h0424, 16'h0425, 16'h0426, 16'h0427, 16'h0428, 16'h0429, 16'h042A,
        16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
        16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004B, 16'h004C, 16'h004E, 16'h004F, 16'h0050,
        16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A
    };

    // Map a code point to its alphabet index by range, without a search
    function automatic alpha_hit_t alpha_lookup(input logic [CODE_W-1:0] code);
        alpha_hit_t res;
        logic [CODE_W-1:0] off;
        res = '0;
        off = '0;
        if (code >= 16'h0410 && code <= 16'h0415) begin
            res.hit = 1'b1;
            off     = code - 16'h0410;
        end else if (code == 16'h0401) begin
            res.hit = 1'b1;
            off     = 16'd6;
        end else if (code >= 16'h0416 && code <= 16'h042F) begin
            res.hit = 1'b1;
            off     = code - 16'h040F;
        end else if (code >= 16'h0041 && code <= 16'h0049) begin
            res.hit = 1'b1;
            off     = code - 16'h0020;
        end else if (code == 16'h004B || code == 16'h004C) begin
            res.hit = 1'b1;
            off     = code - 16'h0021;
        end else if (code >= 16'h004E && code <= 16'h005A) begin
            res.hit = 1'b1;
            off     = code - 16'h0022;
        end
        res.idx = off[IDX_W-1:0];
        return res;
    endfunction

endpackage

### hw/rtl/gsc_key_seq.sv
// ----------------------------------------------------------------------------
// gsc_key_seq
// Configuration registers and key position counter; picks the key digit for
// each accepted character.
// ----------------------------------------------------------------------------
module gsc_key_seq #(
    parameter int MAX_KEY_DIGITS = gsc_pkg::DEFAULT_MAX_KEY_DIGITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [gsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsc_pkg::KEY_W-1:0]      cfg_data,
    input  logic                           accept,
    input  logic                           last,
    output gsc_pkg::key_ctl_t              ctl,
    output logic [gsc_pkg::POS_W-1:0]      key_pos
);

    localparam logic [gsc_pkg::LEN_W-1:0] MaxLen = gsc_pkg::LEN_W'(MAX_KEY_DIGITS);

    logic [gsc_pkg::KEY_W-1:0] key_digits_reg;
    logic [gsc_pkg::LEN_W-1:0] key_length_reg;
    logic                      decrypt_reg;
    logic [gsc_pkg::POS_W-1:0] pos_reg;
    logic [gsc_pkg::POS_W-1:0] pos_next;

    logic [gsc_pkg::LEN_W-1:0]   eff_len;
    logic [gsc_pkg::POS_W-1:0]   pos_use;
    logic [gsc_pkg::LEN_W-1:0]   pos_inc;
    logic [gsc_pkg::DIGIT_W-1:0] digit;

    // Clamp the key length into one..MAX_KEY_DIGITS
    always_comb
    begin
        eff_len = key_length_reg;
        if (eff_len == '0)
            eff_len = gsc_pkg::LEN_W'(1);
        if (eff_len > MaxLen)
            eff_len = MaxLen;
    end

    // Select and clamp the digit for the current position
    always_comb
    begin
        pos_use = pos_reg;
        if ({1'b0, pos_reg} >= eff_len)
            pos_use = '0;
        digit = key_digits_reg[{pos_use, 2'b00} +: gsc_pkg::DIGIT_W];
        ctl.shift   = (digit > gsc_pkg::MAX_DIGIT) ? gsc_pkg::MAX_DIGIT : digit;
        ctl.decrypt = decrypt_reg;
    end

    // Advance the position, wrapping at the key length or after a last beat
    always_comb
    begin
        pos_inc  = {1'b0, pos_use} + gsc_pkg::LEN_W'(1);
        pos_next = pos_reg;
        if (accept)
        begin
            if (pos_inc >= eff_len || last)
                pos_next = '0;
            else
                pos_next = pos_inc[gsc_pkg::POS_W-1:0];
        end
    end

    // Hold configuration and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_digits_reg <= '0;
            key_length_reg <= gsc_pkg::LEN_W'(1);
            decrypt_reg    <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    gsc_pkg::CFG_KEY_DIGITS:   key_digits_reg <= cfg_data;
                    gsc_pkg::CFG_KEY_LENGTH:   key_length_reg <= cfg_data[gsc_pkg::LEN_W-1:0];
                    gsc_pkg::CFG_DECRYPT_MODE: decrypt_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign key_pos = pos_reg;

endmodule

### hw/rtl/gsc_cipher_pipe.sv
// ----------------------------------------------------------------------------
// gsc_cipher_pipe
// Two-register datapath: input register, then alphabet lookup, modular shift
// and letter decode into the result register.
// ----------------------------------------------------------------------------
module gsc_cipher_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gsc_pkg::CODE_W-1:0]  in_code,
    input  logic                        in_last,
    input  gsc_pkg::key_ctl_t           in_ctl,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gsc_pkg::CODE_W-1:0]  out_code,
    output logic                        out_bad,
    output logic                        out_last
);

    localparam logic [gsc_pkg::IDX_W:0] Modulus = (gsc_pkg::IDX_W + 1)'(gsc_pkg::ALPHA_SIZE);

    // Input register
    logic                       s1_valid_reg;
    logic [gsc_pkg::CODE_W-1:0] s1_code_reg;
    logic                       s1_last_reg;
    gsc_pkg::key_ctl_t          s1_ctl_reg;

    // Result register
    logic                       s2_valid_reg;
    logic [gsc_pkg::CODE_W-1:0] s2_code_reg;
    logic                       s2_bad_reg;
    logic                       s2_last_reg;

    logic s2_load;
    logic s1_load;

    gsc_pkg::alpha_hit_t        hit;
    logic [gsc_pkg::IDX_W:0]    sum;
    logic [gsc_pkg::IDX_W:0]    wrapped;
    logic [gsc_pkg::CODE_W-1:0] res_code;

    // Flow control: each stage moves when the one after it has room
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !s2_valid_reg || out_ready;
    assign s1_load  = in_valid && in_ready;

    // Look up, shift modulo the alphabet size and decode the letter
    always_comb
    begin
        hit = gsc_pkg::alpha_lookup(s1_code_reg);
        if (s1_ctl_reg.decrypt)
            sum = {1'b0, hit.idx} + Modulus - (gsc_pkg::IDX_W + 1)'(s1_ctl_reg.shift);
        else
            sum = {1'b0, hit.idx} + (gsc_pkg::IDX_W + 1)'(s1_ctl_reg.shift);
        wrapped = (sum >= Modulus) ? sum - Modulus : sum;
        if (hit.hit)
            res_code = gsc_pkg::ALPHA_CODES[wrapped[gsc_pkg::IDX_W-1:0]];
        else
            res_code = s1_code_reg;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (!s2_valid_reg || out_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_code_reg <= in_code;
            s1_last_reg <= in_last;
            s1_ctl_reg  <= in_ctl;
        end
        if (s2_load)
        begin
            s2_code_reg <= res_code;
            s2_bad_reg  <= !hit.hit;
            s2_last_reg <= s1_last_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_code  = s2_code_reg;
    assign out_bad   = s2_bad_reg;
    assign out_last  = s2_last_reg;

endmodule

### hw/rtl/gronsfeld_stream_cipher.sv
// ----------------------------------------------------------------------------
// gronsfeld_stream_cipher
// Gronsfeld digit-key cipher over a 57-letter Cyrillic and Latin alphabet.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while the output is taken every
// cycle, and each result passes through the input register and then the
// result register, which lie around the lookup and modular add. Each beat's
// key digit is chosen at input time from the key position, which wraps at
// key_length and returns to zero after a tlast beat. A letter outside the
// alphabet comes back unchanged with tuser set and still uses up a key
// digit. Write configuration only while no beat is in flight; cfg_ready is
// always high and indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gronsfeld_stream_cipher #(
    parameter int MAX_KEY_DIGITS = gsc_pkg::DEFAULT_MAX_KEY_DIGITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsc_pkg::KEY_W-1:0]      cfg_data,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gsc_pkg::CODE_W-1:0]     s_tdata,   // [15:0] char_code
    input  logic                           s_tlast,
    // Output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gsc_pkg::CODE_W-1:0]     m_tdata,   // [15:0] out_code
    output logic                           m_tuser,   // [0] bad_char
    output logic                           m_tlast
);

    gsc_pkg::key_ctl_t          key_ctl;
    logic [gsc_pkg::POS_W-1:0]  key_pos;
    logic                       in_accept;
    gsc_pkg::alpha_hit_t        out_hit;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    // Key sequencing and configuration
    gsc_key_seq #(
        .MAX_KEY_DIGITS (MAX_KEY_DIGITS)
    ) u_key_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (in_accept),
        .last      (s_tlast),
        .ctl       (key_ctl),
        .key_pos   (key_pos)
    );

    // Cipher datapath
    gsc_cipher_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_code   (s_tdata),
        .in_last   (s_tlast),
        .in_ctl    (key_ctl),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (m_tdata),
        .out_bad   (m_tuser),
        .out_last  (m_tlast)
    );

    assign out_hit = gsc_pkg::alpha_lookup(m_tdata);

    // A tlast beat sends the key back to its first digit
    `ASSERT_CLK(a_last_rewinds, clk, rst_n, in_accept && s_tlast |=> key_pos == '0, "key position not rewound after last beat")
    // The shift never exceeds nine
    `ASSERT_NEVER(a_shift_clamped, clk, rst_n, key_ctl.shift > gsc_pkg::MAX_DIGIT, "key digit above nine")
    // A good beat always leaves as a letter of the alphabet
    `ASSERT_CLK(a_good_in_alpha, clk, rst_n, m_tvalid && !m_tuser |-> out_hit.hit, "result letter outside alphabet")
    // Input stalls only behind a stalled output
    `ASSERT_CLK(a_stall_cause, clk, rst_n, !s_tready |-> m_tvalid && !m_tready, "input stalled with free output")

endmodule
